// ===== rtl/core/mspg_pkg.sv =====
// shared widths, codes and types for the region growth block
package mspg_pkg;
   localparam int MODE_W     = 2;
   localparam int CIDX_W     = 6;
   localparam int RIDX_W     = 3;
   localparam int CVAL_W     = 32;
   localparam int ORDER_W    = 6;
   localparam int TH_W       = 24;
   localparam int CC_W       = 7;
   localparam int RC_W       = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int FRAC_BITS  = 16;

   localparam logic [TH_W-1:0] TH_RESET = 24'd65536;
   localparam logic [CC_W-1:0] CC_RESET = 7'd64;
   localparam logic [RC_W-1:0] RC_RESET = 4'd1;

   typedef logic [MODE_W-1:0] mode_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam mode_type MODE_LOAD_CITY = 2'd0;
   localparam mode_type MODE_LOAD_SRC  = 2'd1;
   localparam mode_type MODE_RUN       = 2'd2;

   localparam csr_idx_type REG_THRESHOLD    = 2'd0;
   localparam csr_idx_type REG_CITY_COUNT   = 2'd1;
   localparam csr_idx_type REG_REGION_COUNT = 2'd2;
endpackage

// ===== rtl/core/mspg_ifs.sv =====
// valid/ready channel interfaces for requests and claim responses
interface mspg_req_if;
   logic                      valid;
   logic                      ready;
   logic [mspg_pkg::MODE_W-1:0] mode;
   logic [mspg_pkg::CIDX_W-1:0] city_index;
   logic [mspg_pkg::RIDX_W-1:0] region_index;
   logic [mspg_pkg::CVAL_W-1:0] city_value;
   modport source (output valid, mode, city_index, region_index, city_value, input ready);
   modport sink (input valid, mode, city_index, region_index, city_value, output ready);
endinterface

interface mspg_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mspg_pkg::RIDX_W-1:0]  region;
   logic [mspg_pkg::CIDX_W-1:0]  city;
   logic [mspg_pkg::ORDER_W-1:0] order;
   logic                         last;
   modport source (output valid, region, city, order, last, input ready);
   modport sink (input valid, region, city, order, last, output ready);
endinterface

// ===== rtl/core/mspg_ram.sv =====
// generic single write port ram with registered read
module mspg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ===== rtl/core/multi_source_prim_region_growth.sv =====
// region growth top level: loads, candidate scan, neighbour update, claim output
// Loads (mode 0 and 1) write a city value or a source city. A run (mode 2) first sweeps the candidate
// memory clear, one entry a cycle, over MAX_REGIONS times MAX_CITIES entries, each rounded
// up to a power of two, then seeds the sources, then gives each region turn a scan through
// the candidate memory read port; a turn that claims adds an update pass through the shared
// multiply and compare unit, and its claim is held back while the previous claim waits for
// the result side. Claims come out one beat each, the final one marked last; the block takes
// no request until the run has handed over its claims.
module multi_source_prim_region_growth #(
   parameter int MAX_CITIES  = 64,
   parameter int MAX_REGIONS = 8,
   parameter int VALUE_BITS  = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   mspg_req_if.sink                        req_bus,
   mspg_rsp_if.source                      rsp_bus,
   input  logic                            csr_we,
   input  logic [mspg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mspg_pkg::CSR_DATA_W-1:0] csr_wdata
);
   localparam int CIW   = $clog2(MAX_CITIES);
   localparam int RIW   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int AW    = RIW + CIW;
   localparam int CDEP  = 1 << AW;
   localparam int NCW   = $clog2(MAX_CITIES + 1);
   localparam int NRW   = $clog2(MAX_REGIONS + 1);
   localparam int PW    = mspg_pkg::TH_W + VALUE_BITS;
   localparam int BW    = PW - mspg_pkg::FRAC_BITS;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CLEAR = 4'd1;
   localparam logic [3:0] S_INIT  = 4'd2;
   localparam logic [3:0] S_SCAN  = 4'd3;
   localparam logic [3:0] S_EMIT  = 4'd4;
   localparam logic [3:0] S_RDB   = 4'd5;
   localparam logic [3:0] S_RDB2  = 4'd6;
   localparam logic [3:0] S_UPD   = 4'd7;
   localparam logic [3:0] S_FLUSH = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [mspg_pkg::TH_W-1:0] th_ff;
   logic [mspg_pkg::CC_W-1:0] ncnt_ff;
   logic [mspg_pkg::RC_W-1:0] rcnt_ff;
   logic [mspg_pkg::CIDX_W-1:0] src_ff [MAX_REGIONS];
   logic [NCW-1:0] nc_ff, nc_in;
   logic [NRW-1:0] nr_ff, nr_in;
   logic [AW:0] cnt_ff, cnt_in;
   logic [RIW-1:0] turn_ff, turn_in;
   logic [NRW-1:0] idle_ff, idle_in;
   logic [MAX_CITIES-1:0] claimed_ff, claimed_in;
   logic [mspg_pkg::ORDER_W-1:0] counts_ff [MAX_REGIONS];
   logic counts_clr, counts_inc;

   logic s1_v_ff, s1_v_in;
   logic [CIW-1:0] s1_j_ff, s1_j_in;
   logic found_ff, found_in;
   logic [CIW-1:0] best_ff, best_in;
   logic [VALUE_BITS-1:0] bw_ff, bw_in;

   logic [VALUE_BITS-1:0] vb_ff, vb_in;
   logic u1_v_ff, u1_v_in;
   logic [CIW-1:0] u1_j_ff, u1_j_in;
   logic u2_v_ff, u2_v_in;
   logic [CIW-1:0] u2_j_ff;
   logic [VALUE_BITS-1:0] u2_d_ff, u2_ow_ff;
   logic [BW-1:0] u2_bound_ff;
   logic u2_ov_ff;

   logic pend_v_ff, pend_v_in;
   logic [mspg_pkg::RIDX_W-1:0] pend_region_ff, pend_region_in;
   logic [mspg_pkg::CIDX_W-1:0] pend_city_ff, pend_city_in;
   logic [mspg_pkg::ORDER_W-1:0] pend_order_ff, pend_order_in;

   logic rsp_v_ff, rsp_v_in;
   logic [mspg_pkg::RIDX_W-1:0] rsp_region_ff, rsp_region_in;
   logic [mspg_pkg::CIDX_W-1:0] rsp_city_ff, rsp_city_in;
   logic [mspg_pkg::ORDER_W-1:0] rsp_order_ff, rsp_order_in;
   logic rsp_last_ff, rsp_last_in;

   logic city_we;
   logic [CIW-1:0] city_waddr, city_raddr;
   logic [VALUE_BITS-1:0] city_wdata, city_rdata;
   logic cand_we;
   logic [AW-1:0] cand_waddr, cand_raddr;
   logic [VALUE_BITS:0] cand_wdata, cand_rdata;

   logic req_fire, slot_free, push;
   logic [VALUE_BITS-1:0] vj, val_diff;
   logic [VALUE_BITS:0] vsum;
   logic [PW-1:0] prod;
   logic [CIW-1:0] j_cur;
   logic [RIW-1:0] turn_next;
   logic src_ok;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign slot_free     = !rsp_v_ff || rsp_bus.ready;
   assign j_cur         = cnt_ff[CIW-1:0];
   assign turn_next     = (32'(turn_ff) + 32'd1 >= 32'(nr_ff)) ? '0 : RIW'(turn_ff + 1'b1);

   assign rsp_bus.valid  = rsp_v_ff;
   assign rsp_bus.region = rsp_region_ff;
   assign rsp_bus.city   = rsp_city_ff;
   assign rsp_bus.order  = rsp_order_ff;
   assign rsp_bus.last   = rsp_last_ff;

   mspg_ram #(.WIDTH(VALUE_BITS), .DEPTH(1 << CIW)) u_city_ram (
      .clock (clock),
      .we    (city_we),
      .waddr (city_waddr),
      .wdata (city_wdata),
      .raddr (city_raddr),
      .rdata (city_rdata)
   );

   mspg_ram #(.WIDTH(VALUE_BITS + 1), .DEPTH(CDEP)) u_cand_ram (
      .clock (clock),
      .we    (cand_we),
      .waddr (cand_waddr),
      .wdata (cand_wdata),
      .raddr (cand_raddr),
      .rdata (cand_rdata)
   );

   // shared distance and bound unit
   assign vj       = city_rdata;
   assign val_diff = (vb_ff > vj) ? (vb_ff - vj) : (vj - vb_ff);
   assign vsum     = {1'b0, vb_ff} + {1'b0, vj};
   assign prod     = PW'(th_ff) * PW'(vsum[VALUE_BITS:1]);

   assign src_ok = (32'(src_ff[cnt_ff[RIW-1:0]]) < 32'(nc_ff));

   always_comb begin
      city_we    = req_fire && (req_bus.mode == mspg_pkg::MODE_LOAD_CITY) &&
                   (32'(req_bus.city_index) < 32'(MAX_CITIES));
      city_waddr = CIW'(req_bus.city_index);
      city_wdata = VALUE_BITS'(req_bus.city_value);
      city_raddr = (state_ff == S_UPD) ? j_cur : best_ff;
      cand_raddr = {turn_ff, j_cur};
      cand_we    = 1'b0;
      cand_waddr = cnt_ff[AW-1:0];
      cand_wdata = '0;
      case (state_ff)
         S_CLEAR: begin
            cand_we = 1'b1;
         end
         S_INIT: begin
            cand_we    = (32'(cnt_ff) < 32'(nr_ff)) && src_ok;
            cand_waddr = {cnt_ff[RIW-1:0], CIW'(src_ff[cnt_ff[RIW-1:0]])};
            cand_wdata = {1'b1, {VALUE_BITS{1'b0}}};
         end
         S_UPD: begin
            cand_we    = u2_v_ff && !claimed_ff[u2_j_ff] && (u2_d_ff != '0) &&
                         (BW'(u2_d_ff) <= u2_bound_ff) &&
                         (!u2_ov_ff || (u2_d_ff > u2_ow_ff));
            cand_waddr = {turn_ff, u2_j_ff};
            cand_wdata = {1'b1, u2_d_ff};
         end
         default: begin
            cand_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      nc_in          = nc_ff;
      nr_in          = nr_ff;
      cnt_in         = cnt_ff;
      turn_in        = turn_ff;
      idle_in        = idle_ff;
      claimed_in     = claimed_ff;
      counts_clr     = 1'b0;
      counts_inc     = 1'b0;
      s1_v_in        = 1'b0;
      s1_j_in        = j_cur;
      found_in       = found_ff;
      best_in        = best_ff;
      bw_in          = bw_ff;
      vb_in          = vb_ff;
      u1_v_in        = 1'b0;
      u1_j_in        = j_cur;
      u2_v_in        = 1'b0;
      pend_v_in      = pend_v_ff;
      pend_region_in = pend_region_ff;
      pend_city_in   = pend_city_ff;
      pend_order_in  = pend_order_ff;
      push           = 1'b0;
      rsp_region_in  = pend_region_ff;
      rsp_city_in    = pend_city_ff;
      rsp_order_in   = pend_order_ff;
      rsp_last_in    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            nc_in = (32'(ncnt_ff) > 32'(MAX_CITIES)) ? NCW'(MAX_CITIES) : NCW'(ncnt_ff);
            nr_in = (32'(rcnt_ff) > 32'(MAX_REGIONS)) ? NRW'(MAX_REGIONS) : NRW'(rcnt_ff);
            if (req_fire && (req_bus.mode == mspg_pkg::MODE_RUN) &&
                (nc_in != '0) && (nr_in != '0)) begin
               claimed_in = '0;
               counts_clr = 1'b1;
               turn_in    = '0;
               idle_in    = '0;
               cnt_in     = '0;
               state_in   = S_CLEAR;
            end
         end
         S_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (32'(cnt_ff) == CDEP - 1) begin
               cnt_in   = '0;
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            cnt_in = cnt_ff + 1'b1;
            if (32'(cnt_ff) >= 32'(nr_ff)) begin
               cnt_in   = '0;
               found_in = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (32'(cnt_ff) < 32'(nc_ff)) begin
               s1_v_in = 1'b1;
               cnt_in  = cnt_ff + 1'b1;
            end
            if (s1_v_ff) begin
               if (cand_rdata[VALUE_BITS] && !claimed_ff[s1_j_ff] &&
                   (!found_ff || (cand_rdata[VALUE_BITS-1:0] > bw_ff))) begin
                  found_in = 1'b1;
                  best_in  = s1_j_ff;
                  bw_in    = cand_rdata[VALUE_BITS-1:0];
               end
            end else if (32'(cnt_ff) >= 32'(nc_ff)) begin
               if (found_ff) begin
                  state_in = S_EMIT;
               end else if (32'(idle_ff) + 32'd1 >= 32'(nr_ff)) begin
                  state_in = S_FLUSH;
               end else begin
                  idle_in  = idle_ff + 1'b1;
                  turn_in  = turn_next;
                  cnt_in   = '0;
                  found_in = 1'b0;
               end
            end
         end
         S_EMIT: begin
            if (!pend_v_ff || slot_free) begin
               push                = pend_v_ff;
               pend_v_in           = 1'b1;
               pend_region_in      = mspg_pkg::RIDX_W'(turn_ff);
               pend_city_in        = mspg_pkg::CIDX_W'(best_ff);
               pend_order_in       = counts_ff[turn_ff];
               counts_inc          = 1'b1;
               claimed_in[best_ff] = 1'b1;
               state_in            = S_RDB;
            end
         end
         S_RDB: begin
            state_in = S_RDB2;
         end
         S_RDB2: begin
            vb_in    = city_rdata;
            cnt_in   = '0;
            state_in = S_UPD;
         end
         S_UPD: begin
            if (32'(cnt_ff) < 32'(nc_ff)) begin
               u1_v_in = 1'b1;
               cnt_in  = cnt_ff + 1'b1;
            end
            u2_v_in = u1_v_ff;
            if ((32'(cnt_ff) >= 32'(nc_ff)) && !u1_v_ff && !u2_v_ff) begin
               idle_in  = '0;
               turn_in  = turn_next;
               cnt_in   = '0;
               found_in = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_FLUSH: begin
            if (!pend_v_ff) begin
               state_in = S_IDLE;
            end else if (slot_free) begin
               push        = 1'b1;
               rsp_last_in = 1'b1;
               pend_v_in   = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_v_in = push || (rsp_v_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         th_ff     <= mspg_pkg::TH_RESET;
         ncnt_ff   <= mspg_pkg::CC_RESET;
         rcnt_ff   <= mspg_pkg::RC_RESET;
         turn_ff   <= '0;
         idle_ff   <= '0;
         s1_v_ff   <= 1'b0;
         u1_v_ff   <= 1'b0;
         u2_v_ff   <= 1'b0;
         found_ff  <= 1'b0;
         pend_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         turn_ff   <= turn_in;
         idle_ff   <= idle_in;
         s1_v_ff   <= s1_v_in;
         u1_v_ff   <= u1_v_in;
         u2_v_ff   <= u2_v_in;
         found_ff  <= found_in;
         pend_v_ff <= pend_v_in;
         rsp_v_ff  <= rsp_v_in;
         cnt_ff    <= cnt_in;
         if (csr_we) begin
            case (csr_index)
               mspg_pkg::REG_THRESHOLD:    th_ff   <= mspg_pkg::TH_W'(csr_wdata);
               mspg_pkg::REG_CITY_COUNT:   ncnt_ff <= mspg_pkg::CC_W'(csr_wdata);
               mspg_pkg::REG_REGION_COUNT: rcnt_ff <= mspg_pkg::RC_W'(csr_wdata);
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      nc_ff          <= nc_in;
      nr_ff          <= nr_in;
      claimed_in_reg: begin
         claimed_ff <= claimed_in;
      end
      s1_j_ff        <= s1_j_in;
      best_ff        <= best_in;
      bw_ff          <= bw_in;
      vb_ff          <= vb_in;
      u1_j_ff        <= u1_j_in;
      u2_j_ff        <= u1_j_ff;
      u2_d_ff        <= val_diff;
      u2_bound_ff    <= prod[PW-1:mspg_pkg::FRAC_BITS];
      u2_ov_ff       <= cand_rdata[VALUE_BITS];
      u2_ow_ff       <= cand_rdata[VALUE_BITS-1:0];
      pend_region_in_reg: begin
         pend_region_ff <= pend_region_in;
         pend_city_ff   <= pend_city_in;
         pend_order_ff  <= pend_order_in;
      end
      if (push) begin
         rsp_region_ff <= rsp_region_in;
         rsp_city_ff   <= rsp_city_in;
         rsp_order_ff  <= rsp_order_in;
         rsp_last_ff   <= rsp_last_in;
      end
      if (req_fire && (req_bus.mode == mspg_pkg::MODE_LOAD_SRC) &&
          (32'(req_bus.region_index) < 32'(MAX_REGIONS))) begin
         src_ff[RIW'(req_bus.region_index)] <= req_bus.city_index;
      end
      if (counts_clr) begin
         for (int r = 0; r < MAX_REGIONS; r++) begin
            counts_ff[r] <= '0;
         end
      end else if (counts_inc) begin
         counts_ff[turn_ff] <= counts_ff[turn_ff] + 1'b1;
      end
   end
endmodule
